// ===== hw/rtl/mbd_pkg.sv =====
`default_nettype none

package mbd_pkg;

    localparam int WIDTH_REG_W       = 12;
    localparam int HEIGHT_REG_W      = 13;
    localparam int ROW_W             = 12;
    localparam int MAX_HEIGHT        = 4096;
    localparam int MIN_SIZE          = 2;
    localparam int DEFAULT_MAX_WIDTH = 2048;
    localparam int RESET_SIZE        = 256;
    localparam int CHAN_W            = 8;
    localparam int PAIR_W            = CHAN_W + 1;
    localparam int APB_ADDR_W        = 3;
    localparam int APB_DATA_W        = 32;

    // Register index, taken from paddr above the byte offset.
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } pixel_t;

    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic [CHAN_W-1:0] out_alpha;
        logic              last_of_image;
    } result_t;

    // Horizontal pair sums as kept in the line store, red in the low bits.
    typedef struct packed {
        logic [PAIR_W-1:0] alpha;
        logic [PAIR_W-1:0] blue;
        logic [PAIR_W-1:0] green;
        logic [PAIR_W-1:0] red;
    } pair_t;

    typedef struct packed {
        logic [WIDTH_REG_W-1:0]  image_width;
        logic [HEIGHT_REG_W-1:0] image_height;
    } cfg_t;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_HOLD,
        KIND_WRITE,
        KIND_EMIT
    } kind_t;

    typedef struct packed {
        kind_t kind;
        logic  last;
    } scan_t;

endpackage : mbd_pkg

`default_nettype wire

// ===== hw/rtl/mbd_regs.sv =====
`default_nettype none

module mbd_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [mbd_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [mbd_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [mbd_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    output mbd_pkg::cfg_t                       cfg
);
    import mbd_pkg::*;

    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic                    wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_REG_W'(RESET_SIZE);
            height_reg <= HEIGHT_REG_W'(RESET_SIZE);
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_IMAGE_WIDTH:  width_reg  <= pwdata[WIDTH_REG_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= pwdata[HEIGHT_REG_W-1:0];
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(width_reg);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(height_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.image_width  = width_reg;
    assign cfg.image_height = height_reg;

endmodule : mbd_regs

`default_nettype wire

// ===== hw/rtl/mbd_scan.sv =====
`default_nettype none

module mbd_scan #(
    parameter int MAX_WIDTH = mbd_pkg::DEFAULT_MAX_WIDTH
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire mbd_pkg::cfg_t                  cfg,
    input  wire logic                           fire,
    output mbd_pkg::scan_t                      scan,
    output logic      [$clog2(MAX_WIDTH)-1:0]   col
);
    import mbd_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = CW + 1;

    logic [CW-1:0]           col_reg, col_next;
    logic [ROW_W-1:0]        row_reg, row_next;
    logic [WW-1:0]           w, used_w, col_ext, col_inc;
    logic [HEIGHT_REG_W-1:0] h, used_h, row_ext, row_inc;
    logic                    active;

    // Effective size: register value clamped to what the block supports.
    always_comb
    begin
        if (cfg.image_width < WIDTH_REG_W'(MIN_SIZE))
            w = WW'(MIN_SIZE);
        else if (32'(cfg.image_width) > 32'(MAX_WIDTH))
            w = WW'(MAX_WIDTH);
        else
            w = WW'(cfg.image_width);

        if (cfg.image_height < HEIGHT_REG_W'(MIN_SIZE))
            h = HEIGHT_REG_W'(MIN_SIZE);
        else if (32'(cfg.image_height) > 32'(MAX_HEIGHT))
            h = HEIGHT_REG_W'(MAX_HEIGHT);
        else
            h = cfg.image_height;
    end

    assign used_w  = {w[WW-1:1], 1'b0};
    assign used_h  = {h[HEIGHT_REG_W-1:1], 1'b0};
    assign col_ext = WW'(col_reg);
    assign row_ext = HEIGHT_REG_W'(row_reg);
    assign col_inc = col_ext + WW'(1);
    assign row_inc = row_ext + HEIGHT_REG_W'(1);
    assign active  = (col_ext < used_w) && (row_ext < used_h);

    always_comb
    begin
        if (!active)
            scan.kind = KIND_NONE;
        else if (!col_reg[0])
            scan.kind = KIND_HOLD;
        else if (!row_reg[0])
            scan.kind = KIND_WRITE;
        else
            scan.kind = KIND_EMIT;
        scan.last = active && (col_ext == used_w - WW'(1))
                    && (row_ext == used_h - HEIGHT_REG_W'(1));
    end

    assign col = col_reg;

    // A counter found at or beyond the size wraps to zero.
    always_comb
    begin
        row_next = row_reg;
        if (col_inc >= w)
        begin
            col_next = '0;
            if (row_inc >= h)
                row_next = '0;
            else
                row_next = row_inc[ROW_W-1:0];
        end
        else
        begin
            col_next = col_inc[CW-1:0];
            if (row_ext >= h)
                row_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (fire)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule : mbd_scan

`default_nettype wire

// ===== hw/rtl/mbd_filter.sv =====
`default_nettype none

module mbd_filter #(
    parameter int MAX_WIDTH = mbd_pkg::DEFAULT_MAX_WIDTH
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         pixel_valid,
    output logic                              pixel_stall,
    input  wire mbd_pkg::pixel_t              pixel,
    input  wire mbd_pkg::scan_t               scan,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] col,
    output logic                              result_valid,
    input  wire logic                         result_stall,
    output mbd_pkg::result_t                  result
);
    import mbd_pkg::*;

    localparam int CW         = $clog2(MAX_WIDTH);
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int AW         = $clog2(LINE_DEPTH);
    localparam int SUM_W      = PAIR_W + 1;

    logic    en_a, en_b, en_c, a_fire;

    logic    a_valid_reg;
    kind_t   a_kind_reg;
    logic    a_last_reg;
    logic [CW-1:0] a_col_reg;
    pixel_t  a_pix_reg;
    pixel_t  held_reg;
    pair_t   pair;
    logic [AW-1:0] slot;

    logic    b_valid_reg;
    logic    b_last_reg;
    pair_t   b_pair_reg;
    pair_t   top_reg;

    logic    c_valid_reg;
    result_t c_out_reg;

    logic [SUM_W-1:0] sum_r, sum_g, sum_b, sum_a;

    pair_t   line_mem [LINE_DEPTH];

    assign en_c        = !c_valid_reg || !result_stall;
    assign en_b        = !b_valid_reg || en_c;
    assign en_a        = !a_valid_reg || en_b;
    assign pixel_stall = !en_a;
    assign a_fire      = a_valid_reg && en_b;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (en_a)
            a_valid_reg <= pixel_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en_a && pixel_valid)
        begin
            a_kind_reg <= scan.kind;
            a_last_reg <= scan.last;
            a_col_reg  <= col;
            a_pix_reg  <= pixel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            held_reg <= '0;
        else if (a_fire && a_kind_reg == KIND_HOLD)
            held_reg <= a_pix_reg;
    end

    assign pair.red   = PAIR_W'(held_reg.red)   + PAIR_W'(a_pix_reg.red);
    assign pair.green = PAIR_W'(held_reg.green) + PAIR_W'(a_pix_reg.green);
    assign pair.blue  = PAIR_W'(held_reg.blue)  + PAIR_W'(a_pix_reg.blue);
    assign pair.alpha = PAIR_W'(held_reg.alpha) + PAIR_W'(a_pix_reg.alpha);
    assign slot       = a_col_reg[AW:1];

    // Line store. The even row writes a slot and the odd row reads it back
    // on a later beat, so read and write never meet on one slot.
    always_ff @(posedge clk)
    begin
        if (a_fire && a_kind_reg == KIND_WRITE)
            line_mem[slot] <= pair;
        if (a_fire && a_kind_reg == KIND_EMIT)
            top_reg <= line_mem[slot];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (en_b)
            b_valid_reg <= a_valid_reg && (a_kind_reg == KIND_EMIT);
    end

    always_ff @(posedge clk)
    begin
        if (a_fire)
        begin
            b_pair_reg <= pair;
            b_last_reg <= a_last_reg;
        end
    end

    assign sum_r = SUM_W'(top_reg.red)   + SUM_W'(b_pair_reg.red);
    assign sum_g = SUM_W'(top_reg.green) + SUM_W'(b_pair_reg.green);
    assign sum_b = SUM_W'(top_reg.blue)  + SUM_W'(b_pair_reg.blue);
    assign sum_a = SUM_W'(top_reg.alpha) + SUM_W'(b_pair_reg.alpha);

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else if (en_c)
            c_valid_reg <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en_c && b_valid_reg)
        begin
            c_out_reg.out_red       <= sum_r[SUM_W-1:2];
            c_out_reg.out_green     <= sum_g[SUM_W-1:2];
            c_out_reg.out_blue      <= sum_b[SUM_W-1:2];
            c_out_reg.out_alpha     <= sum_a[SUM_W-1:2];
            c_out_reg.last_of_image <= b_last_reg;
        end
    end

    assign result_valid = c_valid_reg;
    assign result       = c_out_reg;

    a_last_is_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && a_last_reg) |-> (a_kind_reg == KIND_EMIT))
        else $error("last flag on a pixel that closes no block");

    stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> (a_valid_reg && b_valid_reg && c_valid_reg))
        else $error("input stalled while the pipeline has a bubble");

    b_holds_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && !en_c) |=> (b_valid_reg && $stable(b_pair_reg)
                                    && $stable(top_reg)))
        else $error("middle stage changed while blocked");

endmodule : mbd_filter

`default_nettype wire

// ===== hw/rtl/mipmap_box_downsample_top.sv =====
`default_nettype none

// 2x2 box-filter mip level generator. Source pixels (RGBA8) arrive in raster
// order, one beat per clock, and the block produces the next level: each
// channel of an output pixel is the sum of its 2x2 block shifted right by two.
// After the beat carrying the block's bottom-right pixel is accepted, its
// result passes through an input register, a stage that holds the line-store
// read, and a result register; one pixel is taken every cycle as long as the
// output side keeps up, and each stage moves on whenever the stage after it
// is empty or moving, so bubbles close up under stall. The line store holds
// MAX_WIDTH/2 entries of 36 bits (four 9-bit pair sums) with at most one
// access per beat and is not cleared after reset. An odd last column or row
// is consumed without output, and last_of_image marks the final pixel of the
// level. image_width (byte address 0) and image_height (address 4) are
// clamped to 2..MAX_WIDTH and 2..4096 and should only be written while idle.
module mipmap_box_downsample_top #(
    parameter int MAX_WIDTH = mbd_pkg::DEFAULT_MAX_WIDTH
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [mbd_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [mbd_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [mbd_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    input  wire logic                           pixel_valid,
    output logic                                pixel_stall,
    input  wire mbd_pkg::pixel_t                pixel,
    output logic                                result_valid,
    input  wire logic                           result_stall,
    output mbd_pkg::result_t                    result
);
    import mbd_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    cfg_t          cfg;
    scan_t         scan;
    logic [CW-1:0] col;
    logic          fire;

    assign fire = pixel_valid && !pixel_stall;

    mbd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mbd_scan #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .fire  (fire),
        .scan  (scan),
        .col   (col)
    );

    mbd_filter #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_filter (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .scan         (scan),
        .col          (col),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule : mipmap_box_downsample_top

`default_nettype wire
